[sv/lct_pkg.sv]
// shared types and constants for the chunk tag cache
`default_nettype none

package lct_pkg;

  localparam int unsigned TAG_W = 32;
  localparam int unsigned OCC_W = 5;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  // state update request from the decision logic to the entry array
  typedef struct packed {
    logic             apply;
    logic             flush;
    logic             grow;
    logic             write_tag;
    logic [TAG_W-1:0] tag;
  } ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [TAG_W-1:0] evicted_index;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

`default_nettype wire

[sv/lru_chunk_tag_cache.sv]
// top level of the fully associative lru chunk tag cache
//
// usage:
//   s_axis carries one request per transfer: tuser selects lookup or flush,
//   tdata holds the chunk index (ignored on flush)
//   m_axis returns exactly one result per request, in order: tuser holds the
//   hit and evicted flags, tdata the evicted chunk index and the occupancy
// a request is held in the request register and its result is then loaded into
//   the result register; one request per cycle while m_axis_tready is high
// throughput is set by the single decide pass between the request register
//   and the result register: all entries are compared in parallel and the
//   entry array is updated at the same edge the result is registered
// a flush passes through like any other request and clears all entries
// reset clears the valid marks, recency ranks, fill count and the valid flags of
//   both pipeline registers; tags are written before they are ever read
// when the receiver stalls, the result register holds, the request register
//   fills and s_axis_tready drops until m_axis_tready returns
`default_nettype none

module lru_chunk_tag_cache #(
  parameter int unsigned MAX_CHUNKS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] chunk_index
  input  wire  [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] evicted_index, [36:32] occupancy
  output logic [1:0]  m_axis_tuser    // [0] hit, [1] evicted
);

  localparam int unsigned AGE_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_CHUNKS + 1);

  // request register
  logic                      req_valid_q;
  lct_pkg::cmd_e             req_cmd_q;
  logic [lct_pkg::TAG_W-1:0] req_index_q;

  // result register
  logic                      res_valid_q;
  lct_pkg::result_t          res_q;

  logic                                       advance;
  lct_pkg::ctrl_t                             ctrl;
  logic [MAX_CHUNKS-1:0]                      slot_oh, age_inc, valid;
  logic [MAX_CHUNKS-1:0][AGE_W-1:0]           age;
  logic [MAX_CHUNKS-1:0][lct_pkg::TAG_W-1:0]  tag;
  logic [FILL_W-1:0]                          fill;
  lct_pkg::result_t                           result_d;

  // request moves on when the result register is free or being drained
  assign advance       = req_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_cmd_q   <= lct_pkg::cmd_e'(s_axis_tuser[0]);
      req_index_q <= s_axis_tdata;
    end
  end

  lct_decide #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .AGE_W      (AGE_W),
    .FILL_W     (FILL_W)
  ) u_decide (
    .apply_i   (advance),
    .cmd_i     (req_cmd_q),
    .index_i   (req_index_q),
    .valid_i   (valid),
    .age_i     (age),
    .tag_i     (tag),
    .fill_i    (fill),
    .ctrl_o    (ctrl),
    .slot_oh_o (slot_oh),
    .age_inc_o (age_inc),
    .result_o  (result_d)
  );

  lct_tag_store #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .AGE_W      (AGE_W),
    .FILL_W     (FILL_W)
  ) u_tag_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .slot_oh_i (slot_oh),
    .age_inc_i (age_inc),
    .valid_o   (valid),
    .age_o     (age),
    .tag_o     (tag),
    .fill_o    (fill)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = {res_q.evicted, res_q.hit};
  assign m_axis_tdata  = {3'b000, res_q.occupancy, res_q.evicted_index};

  // fill count tracks the number of valid entries
  a_fill_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill) == $countones(valid))
    else $error("fill count differs from number of valid entries");

  // an eviction only happens on a miss into a full store
  a_evict_not_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.evicted |-> !res_q.hit &&
      res_q.occupancy == lct_pkg::OCC_W'(MAX_CHUNKS))
    else $error("eviction reported on a hit or a store that is not full");

  // a flush leaves the store empty
  a_flush_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && req_cmd_q == lct_pkg::CMD_FLUSH |=> valid == '0 && fill == '0)
    else $error("entries left valid after flush");

  // a completed request always lands in the result register
  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("result lost after request advanced");

endmodule

`default_nettype wire

[sv/lct_tag_store.sv]
// entry array: tags, valid marks, recency ranks and fill count
`default_nettype none

module lct_tag_store #(
  parameter int unsigned MAX_CHUNKS = 16,
  parameter int unsigned AGE_W      = 4,
  parameter int unsigned FILL_W     = 5
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  lct_pkg::ctrl_t                              ctrl_i,
  input  wire  [MAX_CHUNKS-1:0]                       slot_oh_i,
  input  wire  [MAX_CHUNKS-1:0]                       age_inc_i,
  output logic [MAX_CHUNKS-1:0]                       valid_o,
  output logic [MAX_CHUNKS-1:0][AGE_W-1:0]            age_o,
  output logic [MAX_CHUNKS-1:0][lct_pkg::TAG_W-1:0]   tag_o,
  output logic [FILL_W-1:0]                           fill_o
);

  logic [MAX_CHUNKS-1:0]                     valid_q;
  logic [MAX_CHUNKS-1:0][AGE_W-1:0]          age_q;
  logic [MAX_CHUNKS-1:0][lct_pkg::TAG_W-1:0] tag_q;
  logic [FILL_W-1:0]                         fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
      fill_q  <= '0;
    end else if (ctrl_i.apply) begin
      if (ctrl_i.flush) begin
        valid_q <= '0;
        age_q   <= '0;
        fill_q  <= '0;
      end else begin
        for (int i = 0; i < MAX_CHUNKS; i++) begin
          if (slot_oh_i[i]) begin
            valid_q[i] <= 1'b1;
            age_q[i]   <= '0;
          end else if (age_inc_i[i]) begin
            age_q[i] <= age_q[i] + AGE_W'(1);
          end
        end
        if (ctrl_i.grow) begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
    end
  end

  // tags are only read while their entry is valid
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply && ctrl_i.write_tag) begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        if (slot_oh_i[i]) begin
          tag_q[i] <= ctrl_i.tag;
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign age_o   = age_q;
  assign tag_o   = tag_q;
  assign fill_o  = fill_q;

endmodule

`default_nettype wire

[sv/lct_decide.sv]
// tag compare, victim choice and recency update for one item
`default_nettype none

module lct_decide #(
  parameter int unsigned MAX_CHUNKS = 16,
  parameter int unsigned AGE_W      = 4,
  parameter int unsigned FILL_W     = 5
) (
  input  wire                                         apply_i,
  input  lct_pkg::cmd_e                               cmd_i,
  input  wire  [lct_pkg::TAG_W-1:0]                   index_i,
  input  wire  [MAX_CHUNKS-1:0]                       valid_i,
  input  wire  [MAX_CHUNKS-1:0][AGE_W-1:0]            age_i,
  input  wire  [MAX_CHUNKS-1:0][lct_pkg::TAG_W-1:0]   tag_i,
  input  wire  [FILL_W-1:0]                           fill_i,
  output lct_pkg::ctrl_t                              ctrl_o,
  output logic [MAX_CHUNKS-1:0]                       slot_oh_o,
  output logic [MAX_CHUNKS-1:0]                       age_inc_o,
  output lct_pkg::result_t                            result_o
);

  logic [MAX_CHUNKS-1:0]     match, hit_oh, free_oh, oldest, oldest_oh;
  logic                      is_flush, hit, full, evict;
  logic [AGE_W-1:0]          hit_age;
  logic [lct_pkg::TAG_W-1:0] victim_tag;
  logic [FILL_W-1:0]         fill_next;

  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      match[i]  = valid_i[i] && (tag_i[i] == index_i);
      oldest[i] = valid_i[i] && (age_i[i] == AGE_W'(MAX_CHUNKS - 1));
    end
  end

  // lowest set bit wins
  assign hit_oh    = match & (~match + MAX_CHUNKS'(1));
  assign free_oh   = ~valid_i & (valid_i + MAX_CHUNKS'(1));
  assign oldest_oh = oldest & (~oldest + MAX_CHUNKS'(1));

  assign is_flush = (cmd_i == lct_pkg::CMD_FLUSH);
  assign hit      = !is_flush && (|match);
  assign full     = (fill_i == FILL_W'(MAX_CHUNKS));
  assign evict    = !is_flush && !hit && full;

  always_comb begin
    hit_age    = '0;
    victim_tag = '0;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      hit_age    = hit_age | (age_i[i] & {AGE_W{hit_oh[i]}});
      victim_tag = victim_tag | (tag_i[i] & {lct_pkg::TAG_W{oldest_oh[i]}});
    end
  end

  always_comb begin
    priority if (is_flush) begin
      slot_oh_o = '0;
    end else if (hit) begin
      slot_oh_o = hit_oh;
    end else if (full) begin
      slot_oh_o = oldest_oh;
    end else begin
      slot_oh_o = free_oh;
    end
  end

  // on a hit only entries younger than the hit entry age, on a miss all do
  always_comb begin
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      age_inc_o[i] = valid_i[i] && !is_flush && (!hit || (age_i[i] < hit_age));
    end
  end

  assign ctrl_o.apply     = apply_i;
  assign ctrl_o.flush     = is_flush;
  assign ctrl_o.grow      = !is_flush && !hit && !full;
  assign ctrl_o.write_tag = !is_flush && !hit;
  assign ctrl_o.tag       = index_i;

  assign fill_next = is_flush ? '0 : (ctrl_o.grow ? fill_i + FILL_W'(1) : fill_i);

  always_comb begin
    result_o               = '0;
    result_o.hit           = hit;
    result_o.evicted       = evict;
    result_o.evicted_index = evict ? victim_tag : '0;
    // fill count taken to the width of the occupancy field
    result_o.occupancy     = lct_pkg::OCC_W'(fill_next);
  end

endmodule

`default_nettype wire
